FILE: src/yuvrgb_pkg.sv
package yuvrgb_pkg;

	localparam int MAX_LINE_WIDTH  = 1024;
	localparam int MAX_FRAME_LINES = 1024;

	// column / line counter widths and effective-size widths
	localparam int COL_W  = $clog2(MAX_LINE_WIDTH);
	localparam int LINE_W = $clog2(MAX_FRAME_LINES);
	localparam int W_W    = COL_W + 1;
	localparam int H_W    = LINE_W + 1;
	localparam int PROD_W = W_W + H_W;

	// chroma line store: one U/V pair per column pair
	localparam int STORE_DEPTH = MAX_LINE_WIDTH / 2;
	localparam int SLOT_W      = $clog2(STORE_DEPTH);
	localparam int PAIR_W      = 16;

	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int IDX_W      = 20;
	localparam int CSC_W      = 20;

	localparam int LINE_WIDTH_RESET  = 640;
	localparam int FRAME_LINES_RESET = 480;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINE_WIDTH  = 2'd0,
		CFG_FRAME_LINES = 2'd1,
		CFG_PORTRAIT    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] luma;
		logic [7:0] chroma_blue;
		logic [7:0] chroma_red;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [IDX_W-1:0] pixel_index;
		logic             frame_end;
	} out_item_t;

	// per-pixel position info from the counter stage
	typedef struct packed {
		logic              wr_pair;
		logic [SLOT_W-1:0] slot;
		logic [IDX_W-1:0]  pixel_index;
		logic              frame_end;
	} pos_t;

	// clamp to 2..maxv, then force even
	function automatic int eff_size(input int v, input int maxv);
		int r;
		r = v;
		if (r < 2) r = 2;
		if (r > maxv) r = maxv;
		return r & ~1;
	endfunction

	// 8.8 value -> 0..255, floor shift
	function automatic logic [7:0] clamp_channel(input logic signed [CSC_W-1:0] x);
		logic [7:0] r;
		if (x < 0) begin
			r = 8'd0;
		end else if (x[CSC_W-1:8] > 255) begin
			r = 8'd255;
		end else begin
			r = x[15:8];
		end
		return r;
	endfunction

endpackage

FILE: src/yuvrgb_ram.sv
module yuvrgb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/yuvrgb_ctr.sv
module yuvrgb_ctr (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            advance,
	input  logic [yuvrgb_pkg::W_W-1:0]      w_eff,
	input  logic [yuvrgb_pkg::H_W-1:0]      h_eff,
	input  logic                            portrait,
	output yuvrgb_pkg::pos_t                pos
);

	logic [yuvrgb_pkg::COL_W-1:0]  col_q;
	logic [yuvrgb_pkg::LINE_W-1:0] line_q;

	logic                           wrap_pre;
	logic [yuvrgb_pkg::H_W-1:0]    line_pre;
	logic [yuvrgb_pkg::COL_W-1:0]  col;
	logic [yuvrgb_pkg::LINE_W-1:0] line;
	logic [yuvrgb_pkg::W_W-1:0]    col_inc;
	logic [yuvrgb_pkg::H_W-1:0]    line_inc;
	logic [yuvrgb_pkg::COL_W-1:0]  col_n;
	logic [yuvrgb_pkg::LINE_W-1:0] line_n;
	logic [yuvrgb_pkg::PROD_W-1:0] mul_a;
	logic [yuvrgb_pkg::PROD_W-1:0] mul_b;
	logic [yuvrgb_pkg::PROD_W-1:0] add_c;
	logic [yuvrgb_pkg::PROD_W-1:0] idx_full;

	// counters may sit past a size that was just shrunk: wrap before use
	always_comb begin
		wrap_pre = {1'b0, col_q} >= w_eff;
		line_pre = {1'b0, line_q} + yuvrgb_pkg::H_W'(wrap_pre);
		col      = wrap_pre ? '0 : col_q;
		line     = (line_pre >= h_eff) ? '0 : line_pre[yuvrgb_pkg::LINE_W-1:0];
		col_inc  = {1'b0, col} + yuvrgb_pkg::W_W'(1);
		line_inc = {1'b0, line} + yuvrgb_pkg::H_W'(1);
		if (col_inc >= w_eff) begin
			col_n  = '0;
			line_n = (line_inc >= h_eff) ? '0 : line_inc[yuvrgb_pkg::LINE_W-1:0];
		end else begin
			col_n  = col_inc[yuvrgb_pkg::COL_W-1:0];
			line_n = line;
		end
	end

	// one shared multiplier: raster line*W+col, portrait (W-1-col)*H+line
	always_comb begin
		if (portrait) begin
			mul_a = yuvrgb_pkg::PROD_W'(w_eff - yuvrgb_pkg::W_W'(1) - {1'b0, col});
			mul_b = yuvrgb_pkg::PROD_W'(h_eff);
			add_c = yuvrgb_pkg::PROD_W'(line);
		end else begin
			mul_a = yuvrgb_pkg::PROD_W'(line);
			mul_b = yuvrgb_pkg::PROD_W'(w_eff);
			add_c = yuvrgb_pkg::PROD_W'(col);
		end
		idx_full = mul_a * mul_b + add_c;
	end

	always_comb begin
		pos.wr_pair     = !line[0] && !col[0];
		pos.slot        = col[yuvrgb_pkg::COL_W-1:1];
		pos.pixel_index = yuvrgb_pkg::IDX_W'(idx_full);
		pos.frame_end   = ({1'b0, col} == w_eff - yuvrgb_pkg::W_W'(1)) &&
		                  ({1'b0, line} == h_eff - yuvrgb_pkg::H_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			line_q <= '0;
		end else if (advance) begin
			col_q  <= col_n;
			line_q <= line_n;
		end
	end

endmodule

FILE: src/yuvrgb_csc.sv
module yuvrgb_csc (
	input  logic [7:0]                    luma,
	input  logic [yuvrgb_pkg::PAIR_W-1:0] pair,
	output logic [7:0]                    red,
	output logic [7:0]                    green,
	output logic [7:0]                    blue
);

	logic signed [9:0]                   u;
	logic signed [9:0]                   v;
	logic signed [yuvrgb_pkg::CSC_W-1:0] y_s;
	logic signed [yuvrgb_pkg::CSC_W-1:0] u_s;
	logic signed [yuvrgb_pkg::CSC_W-1:0] v_s;
	logic signed [yuvrgb_pkg::CSC_W-1:0] r_sum;
	logic signed [yuvrgb_pkg::CSC_W-1:0] g_sum;
	logic signed [yuvrgb_pkg::CSC_W-1:0] b_sum;

	// U in high byte, V in low byte; 8.8 coefficients
	always_comb begin
		u     = $signed({2'b00, pair[15:8]}) - 10'sd128;
		v     = $signed({2'b00, pair[7:0]}) - 10'sd128;
		y_s   = $signed({4'b0000, luma, 8'h00});
		u_s   = yuvrgb_pkg::CSC_W'(u);
		v_s   = yuvrgb_pkg::CSC_W'(v);
		r_sum = y_s + v_s * 20'sd359;
		g_sum = y_s - u_s * 20'sd88 - v_s * 20'sd183;
		b_sum = y_s + u_s * 20'sd454;
		red   = yuvrgb_pkg::clamp_channel(r_sum);
		green = yuvrgb_pkg::clamp_channel(g_sum);
		blue  = yuvrgb_pkg::clamp_channel(b_sum);
	end

endmodule

FILE: src/yuv420_to_rgb_rotate_top.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall   in_item_t  (luma, chroma_blue, chroma_red)
// out       output     out_valid / out_stall out_item_t (red, green, blue, pixel_index,
//                                            frame_end)
// cfg       input      cfg_we                cfg_index, cfg_wdata (no read-back)
//
// One pixel per clock sustained while out_stall is low; after the input transfer the pixel
// passes through the stage 1 register and the output register before out_valid rises.
// Stage 0 (input transfer): counters, destination index multiply, line store access.
// Stage 1 -> output register: color conversion, four constant multiplies and clamps.
// Reset clears counters and valid flags and loads the config reset values; the line store is not cleared.
// in_stall rises only when both stage 1 and the output register hold pixels and
// out_stall is high; no pixel is dropped.
module yuv420_to_rgb_rotate_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  yuvrgb_pkg::in_item_t              in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output yuvrgb_pkg::out_item_t             out_data,
	input  logic                              cfg_we,
	input  logic [yuvrgb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [yuvrgb_pkg::CFG_W-1:0]      cfg_wdata
);

	// config, held as effective (clamped, even) sizes
	logic [yuvrgb_pkg::W_W-1:0] w_eff_q;
	logic [yuvrgb_pkg::H_W-1:0] h_eff_q;
	logic                       portrait_q;

	// stage 1
	logic                            valid_s1;
	logic [7:0]                      luma_s1;
	logic [yuvrgb_pkg::PAIR_W-1:0]   pair_s1;
	logic                            use_store_s1;
	logic [yuvrgb_pkg::IDX_W-1:0]    idx_s1;
	logic                            last_s1;

	// output register
	logic                  out_valid_q;
	yuvrgb_pkg::out_item_t out_q;

	logic                          in_xfer;
	logic                          out_free;
	logic                          s1_free;
	logic                          ram_we;
	logic                          ram_re;
	logic [yuvrgb_pkg::PAIR_W-1:0] in_pair;
	logic [yuvrgb_pkg::PAIR_W-1:0] store_rd;
	logic [yuvrgb_pkg::PAIR_W-1:0] pair_sel;
	logic [7:0]                    red_c;
	logic [7:0]                    green_c;
	logic [7:0]                    blue_c;
	yuvrgb_pkg::pos_t              pos;

	// handshake: output register frees when empty or taken
	assign out_free  = !out_valid_q || !out_stall;
	assign s1_free   = !valid_s1 || out_free;
	assign in_stall  = !s1_free;
	assign in_xfer   = in_valid && s1_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_eff_q    <= yuvrgb_pkg::W_W'(yuvrgb_pkg::eff_size(
			              yuvrgb_pkg::LINE_WIDTH_RESET, yuvrgb_pkg::MAX_LINE_WIDTH));
			h_eff_q    <= yuvrgb_pkg::H_W'(yuvrgb_pkg::eff_size(
			              yuvrgb_pkg::FRAME_LINES_RESET, yuvrgb_pkg::MAX_FRAME_LINES));
			portrait_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				yuvrgb_pkg::CFG_LINE_WIDTH: begin
					w_eff_q <= yuvrgb_pkg::W_W'(yuvrgb_pkg::eff_size(
					           int'(cfg_wdata), yuvrgb_pkg::MAX_LINE_WIDTH));
				end
				yuvrgb_pkg::CFG_FRAME_LINES: begin
					h_eff_q <= yuvrgb_pkg::H_W'(yuvrgb_pkg::eff_size(
					           int'(cfg_wdata), yuvrgb_pkg::MAX_FRAME_LINES));
				end
				yuvrgb_pkg::CFG_PORTRAIT: begin
					portrait_q <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	yuvrgb_ctr u_ctr (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (in_xfer),
		.w_eff    (w_eff_q),
		.h_eff    (h_eff_q),
		.portrait (portrait_q),
		.pos      (pos)
	);

	// even column of even line writes the pair, every other pixel reads it;
	// a pixel never does both, so no bypass is needed
	assign in_pair = {in_data.chroma_blue, in_data.chroma_red};
	assign ram_we  = in_xfer && pos.wr_pair;
	assign ram_re  = in_xfer && !pos.wr_pair;

	yuvrgb_ram #(
		.WIDTH (yuvrgb_pkg::PAIR_W),
		.DEPTH (yuvrgb_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos.slot),
		.wdata (in_pair),
		.re    (ram_re),
		.raddr (pos.slot),
		.rdata (store_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			luma_s1      <= in_data.luma;
			pair_s1      <= in_pair;
			use_store_s1 <= !pos.wr_pair;
			idx_s1       <= pos.pixel_index;
			last_s1      <= pos.frame_end;
		end
	end

	// store read data is held while stage 1 waits (read only on transfer)
	assign pair_sel = use_store_s1 ? store_rd : pair_s1;

	yuvrgb_csc u_csc (
		.luma  (luma_s1),
		.pair  (pair_sel),
		.red   (red_c),
		.green (green_c),
		.blue  (blue_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			out_q.red         <= red_c;
			out_q.green       <= green_c;
			out_q.blue        <= blue_c;
			out_q.pixel_index <= idx_s1;
			out_q.frame_end   <= last_s1;
		end
	end

`ifndef SYNTHESIS
	a_store_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("line store written and read by the same pixel");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled while pipeline has room");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && out_stall) |=> valid_s1)
		else $error("stage 1 pixel lost during output stall");

	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("output valid without a stage 1 pixel");
`endif

endmodule

FILE: sim/yuv420_to_rgb_rotate_top_tb.sv
module yuv420_to_rgb_rotate_top_tb;
	import yuvrgb_pkg::*;

	// index 3 has no register behind it; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	// two-stage pipe, a little slack on top
	localparam int DRAIN_CYCLES = 4;
	localparam int CYCLE_LIMIT = 800000;
	localparam int RANDOM_PIXELS = 280;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	yuv420_to_rgb_rotate_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Converter shadow: register copies, raster counters, chroma line store
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] width_reg = CFG_W'(LINE_WIDTH_RESET);
	logic [CFG_W-1:0] lines_reg = CFG_W'(FRAME_LINES_RESET);
	logic portrait_reg = 1'b0;
	int col_pos = 0;
	int line_pos = 0;
	logic [15:0] uv_store [STORE_DEPTH];	// U high byte, V low byte

	out_item_t pending_pixels[$];	// expected RGB results, oldest first
	int n_sent = 0;
	int n_checked = 0;
	int n_mismatch = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;

	// clamp to 2..maxv, then drop to even
	function automatic int even_size(int v, int maxv);
		if (v < 2) v = 2;
		if (v > maxv) v = maxv;
		return v - (v % 2);
	endfunction

	// 8.8 accumulator -> 0..255; >> on a non-negative value is the floor
	function automatic logic [7:0] sat_byte(int acc);
		if (acc < 0) return 8'd0;
		if ((acc >> 8) > 255) return 8'd255;
		return 8'(acc >> 8);
	endfunction

	// Convert one accepted pixel and advance the raster counters.
	function automatic out_item_t convert_pixel(in_item_t px);
		int w, h, col, line, slot, y, u, v;
		logic [15:0] uv;
		out_item_t res;
		w = even_size(width_reg, MAX_LINE_WIDTH);
		h = even_size(lines_reg, MAX_FRAME_LINES);
		// size may have shrunk since the last pixel
		if (col_pos >= w) begin
			col_pos = 0;
			line_pos++;
		end
		if (line_pos >= h) line_pos = 0;
		col = col_pos;
		line = line_pos;
		slot = (col / 2) % STORE_DEPTH;
		// chroma sampled at even column of even line, reused elsewhere
		if ((line % 2 == 0) && (col % 2 == 0)) begin
			uv = {px.chroma_blue, px.chroma_red};
			uv_store[slot] = uv;
		end else begin
			uv = uv_store[slot];
		end
		y = int'(px.luma) * 256;
		u = int'(uv[15:8]) - 128;
		v = int'(uv[7:0]) - 128;
		res.red = sat_byte(y + 359 * v);
		res.green = sat_byte(y - 88 * u - 183 * v);
		res.blue = sat_byte(y + 454 * u);
		if (portrait_reg) res.pixel_index = IDX_W'((w - 1 - col) * h + line);
		else res.pixel_index = IDX_W'(line * w + col);
		res.frame_end = (col == w - 1) && (line == h - 1);
		col_pos = col + 1;
		line_pos = line;
		if (col_pos >= w) begin
			col_pos = 0;
			line_pos = line + 1;
			if (line_pos >= h) line_pos = 0;
		end
		return res;
	endfunction

	function automatic in_item_t random_pixel();
		in_item_t px;
		px = 24'($urandom);
		return px;
	endfunction

	// ------------------------------------------------------------------
	// Input side: bursts of transfers with random gaps between them.
	// in_valid stays high across back-to-back transfers.
	// ------------------------------------------------------------------
	task automatic send_pixel(in_item_t px);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= px;
		do @(posedge clk); while (in_stall);
		pending_pixels.push_back(convert_pixel(px));
		n_sent++;
	endtask

	task automatic send_random(int n);
		repeat (n) send_pixel(random_pixel());
	endtask

	// run on until the counters are back at the frame origin
	task automatic finish_frame();
		while (!(col_pos == 0 && line_pos == 0)) send_pixel(random_pixel());
	endtask

	task automatic full_frame();
		finish_frame();
		send_pixel(random_pixel());
		finish_frame();
	endtask

	// no input transfer in flight, every result back, pipe drained
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_LINE_WIDTH: width_reg = val;
			CFG_FRAME_LINES: lines_reg = val;
			CFG_PORTRAIT: portrait_reg = val[0];
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset config (640x480 raster), start of line 0. Field extremes and
	// clamp corners; odd columns carry junk chroma that must be ignored.
	task automatic test_default_pixels();
		in_item_t corner [20];
		corner = '{24'h008080, 24'hFF0000, 24'hFFFFFF, 24'h00FFFF, 24'h000000,
			24'hFFFFFF, 24'h8000FF, 24'h01FF00, 24'h80FF00, 24'hFE00FF,
			24'h80FFFF, 24'h800000, 24'h000080, 24'hFF8000, 24'h00FF80,
			24'h7F7F7F, 24'hAA55AA, 24'h55AA55, 24'hFF0080, 24'h80807F};
		foreach (corner[i]) send_pixel(corner[i]);
	endtask

	// Grow the line to full width mid-line: line 0 then fills every store
	// slot, so nothing read later is ever unwritten. Odd columns of line 0
	// read every slot back; line 1 is cut short to keep the run brief.
	task automatic test_store_fill();
		write_reg(CFG_FRAME_LINES, 11'd2);
		write_reg(CFG_LINE_WIDTH, 11'd1024);
		while (line_pos == 0) send_pixel(random_pixel());
		write_reg(CFG_LINE_WIDTH, 11'd8);
		finish_frame();
	endtask

	// Widest line in portrait (cut short by a shrink), smallest frames in
	// both orientations.
	task automatic test_size_extremes();
		write_reg(CFG_PORTRAIT, 11'd1);
		write_reg(CFG_LINE_WIDTH, 11'd1024);
		send_random(40);
		write_reg(CFG_LINE_WIDTH, 11'd2);	// column past the end: wraps
		finish_frame();
		full_frame();	// 2 x 2
		write_reg(CFG_PORTRAIT, 11'd0);
		full_frame();
	endtask

	// Sizes below 2, odd sizes and sizes above the maximum.
	task automatic test_out_of_range();
		write_reg(CFG_LINE_WIDTH, 11'd0);
		write_reg(CFG_FRAME_LINES, 11'd1);
		write_reg(CFG_PORTRAIT, 11'd0);
		full_frame();
		write_reg(CFG_LINE_WIDTH, 11'd1);
		write_reg(CFG_FRAME_LINES, 11'd0);
		write_reg(CFG_PORTRAIT, 11'd1);
		full_frame();
		write_reg(CFG_LINE_WIDTH, 11'd7);
		write_reg(CFG_FRAME_LINES, 11'd9);
		full_frame();
		// 1024 x 1024 in portrait: top of the index range on line 0
		write_reg(CFG_LINE_WIDTH, 11'd1025);
		write_reg(CFG_FRAME_LINES, 11'd2047);
		write_reg(CFG_PORTRAIT, 11'd2047);	// only bit 0 counts
		send_random(24);
		write_reg(CFG_FRAME_LINES, 11'd1);
		write_reg(CFG_LINE_WIDTH, 11'd3);
		finish_frame();
	endtask

	// Size changes in the middle of a frame: column wrap, line wrap, growth.
	task automatic test_midframe_change();
		write_reg(CFG_PORTRAIT, 11'd2046);
		write_reg(CFG_LINE_WIDTH, 11'd16);
		write_reg(CFG_FRAME_LINES, 11'd8);
		full_frame();
		send_random(37);	// stops at line 2, column 5
		write_reg(CFG_LINE_WIDTH, 11'd4);	// column past the end: wraps
		send_random(10);	// stops at line 5
		write_reg(CFG_FRAME_LINES, 11'd4);	// line past the end: wraps
		send_random(5);
		write_reg(CFG_PORTRAIT, 11'd1);
		write_reg(CFG_LINE_WIDTH, 11'd20);
		send_random(30);
		finish_frame();
	endtask

	task automatic test_spare_index();
		write_reg(CFG_SPARE, 11'd2047);
		full_frame();
		write_reg(CFG_SPARE, 11'd0);
		full_frame();
	endtask

	// Random sizes and orientation, written between stretches of pixels,
	// mostly small frames so frame ends come often.
	task automatic test_random_frames();
		int start, n;
		start = n_sent;
		while (n_sent - start < RANDOM_PIXELS) begin
			if ($urandom_range(0, 1) == 0)
				write_reg(CFG_LINE_WIDTH, ($urandom_range(0, 7) == 0) ?
					11'($urandom_range(0, 2047)) : 11'($urandom_range(0, 32)));
			if ($urandom_range(0, 1) == 0)
				write_reg(CFG_FRAME_LINES, ($urandom_range(0, 7) == 0) ?
					11'($urandom_range(0, 2047)) : 11'($urandom_range(0, 16)));
			if ($urandom_range(0, 1) == 0)
				write_reg(CFG_PORTRAIT, 11'($urandom_range(0, 2047)));
			if ($urandom_range(0, 15) == 0)
				write_reg(CFG_SPARE, 11'($urandom_range(0, 2047)));
			n = $urandom_range(10, 150);
			send_random(n);
			if (even_size(width_reg, MAX_LINE_WIDTH) * even_size(lines_reg, MAX_FRAME_LINES)
				<= 512 && $urandom_range(0, 2) == 0)
				finish_frame();
		end
	endtask

	// ------------------------------------------------------------------
	// Output side: stall pattern, result check, cycle limit.
	// Everything here samples pre-edge values at the rising edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		out_item_t want;
		logic bad;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("yuv420_to_rgb_rotate_top_tb: FAIL");
			$finish;
		end else begin
			if (arst_n && out_valid && !out_stall) begin
				if (pending_pixels.size() == 0) begin
					if (n_mismatch < 10)
						$display("unexpected result transfer: r=%0d g=%0d b=%0d idx=%0d end=%0b",
							out_data.red, out_data.green, out_data.blue,
							out_data.pixel_index, out_data.frame_end);
					n_mismatch++;
				end else begin
					want = pending_pixels.pop_front();
					bad = (out_data.red !== want.red) || (out_data.green !== want.green) ||
						(out_data.blue !== want.blue) ||
						(out_data.pixel_index !== want.pixel_index) ||
						(out_data.frame_end !== want.frame_end);
					if (bad) begin
						if (n_mismatch < 10)
							$display("result %0d: expected r=%0d g=%0d b=%0d idx=%0d end=%0b, got r=%0d g=%0d b=%0d idx=%0d end=%0b",
								n_checked, want.red, want.green, want.blue,
								want.pixel_index, want.frame_end,
								out_data.red, out_data.green, out_data.blue,
								out_data.pixel_index, out_data.frame_end);
						n_mismatch++;
					end
					n_checked++;
				end
			end
			// stall pattern: free-running, light, heavy, periodic
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(20, 200);
			end
			stall_left--;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 2) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= cycle_count[2];
			endcase
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_pixels();
		test_store_fill();
		test_size_extremes();
		test_out_of_range();
		test_midframe_change();
		test_spare_index();
		test_random_frames();
		wait_idle();
		if (n_mismatch == 0) begin
			$display("yuv420_to_rgb_rotate_top_tb: PASS");
		end else begin
			$display("yuv420_to_rgb_rotate_top_tb: FAIL");
		end
		$finish;
	end

endmodule
